FILE: design/dq_pkg.sv
// Shared constants and operation codes for the double-ended queue.
`timescale 1ns / 1ps
package dq_pkg;

  localparam int DqDepthDefault = 16;
  localparam int DqDataW        = 32;
  localparam int DqOpW          = 3;
  localparam int DqPosW         = 8;
  localparam int DqCountW       = 5;
  localparam int DqInTdataW     = 48;
  localparam int DqOutTdataW    = 40;

  typedef enum logic [DqOpW-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REMOVE     = 3'd4,
    OP_READ       = 3'd5,
    OP_CLEAR      = 3'd6
  } dq_op_e;

endpackage

FILE: design/dq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: design/double_ended_queue_top.sv
// Top level of the bounded double-ended queue with its ring store and sequencer.
`timescale 1ns / 1ps
// A bounded double-ended queue of signed 32-bit values kept in a ring of DEPTH
// entries in one RAM with a single read and a single write port. Each input item
// carries one operation and returns exactly one result item holding the popped or
// read value, a success flag and the number of entries held afterwards. Items are
// handled one at a time: pushes and clear go from the execute state straight to
// the result state, pops and reads pass through a wait state for the registered
// RAM read, and a remove scans the ring one entry per cycle and then moves each
// later entry one place toward the front, one per cycle, through the same read
// port. A finished result waits in the output register while the block returns
// to accepting input; the next result that finds that register still occupied
// holds the block until the waiting item is taken.
module double_ended_queue_top
  import dq_pkg::*;
#(
  parameter int DEPTH = DqDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // Fields from bit 0: operation[2:0], value[34:3], position[42:35], zero fill.
  input  logic [DqInTdataW-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // Fields from bit 0: data[31:0], ok[32], count[37:33], zero fill.
  output logic [DqOutTdataW-1:0] m_axis_tdata
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > DqPosW) ? CNT_W : DqPosW;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_e;

  state_e                   state_q, state_d;
  logic [DqOpW-1:0]         op_q, op_d;
  logic signed [DqDataW-1:0] val_q, val_d;
  logic [DqPosW-1:0]        pos_q, pos_d;
  logic [PTR_W-1:0]         front_q, front_d;
  logic [CNT_W-1:0]         count_q, count_d;
  logic [PTR_W-1:0]         idx_q, idx_d;
  logic [DqDataW-1:0]       data_q, data_d;
  logic                     ok_q, ok_d;
  logic                     m_valid_q, m_valid_d;
  logic [DqDataW-1:0]       m_data_q, m_data_d;
  logic                     m_ok_q, m_ok_d;
  logic [DqCountW-1:0]      m_count_q, m_count_d;

  logic                     ram_we;
  logic [PTR_W-1:0]         ram_waddr;
  logic [DqDataW-1:0]       ram_wdata;
  logic                     ram_re;
  logic [PTR_W-1:0]         ram_raddr;
  logic [DqDataW-1:0]       ram_rdata;

  logic [PTR_W-1:0]         front_dec;
  logic [PTR_W-1:0]         front_inc;
  logic [CNT_W-1:0]         read_pos;
  logic [CNT_W:0]           idx_p1;
  logic [CNT_W:0]           idx_p2;
  logic [CNT_W:0]           count_x;

  // Ring index of the entry at a given distance from the front.
  function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + (CNT_W+1)'(off);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  dq_ram #(
    .WIDTH(DqDataW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;
  assign idx_p1    = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
  assign idx_p2    = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
  assign count_x   = (CNT_W+1)'(count_q);

  // A read position at or beyond the end selects the last entry.
  assign read_pos = (CMP_W'(pos_q) >= CMP_W'(count_q)) ? count_q - 1'b1 : CNT_W'(pos_q);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(DqOutTdataW - DqDataW - 1 - DqCountW){1'b0}},
                          m_count_q, m_ok_q, m_data_q};

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    val_d     = val_q;
    pos_d     = pos_q;
    front_d   = front_q;
    count_d   = count_q;
    idx_d     = idx_q;
    data_d    = data_q;
    ok_d      = ok_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_ok_d    = m_ok_q;
    m_count_d = m_count_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = val_q;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = s_axis_tdata[DqOpW-1:0];
          val_d   = s_axis_tdata[DqOpW +: DqDataW];
          pos_d   = s_axis_tdata[DqOpW + DqDataW +: DqPosW];
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ok_d    = 1'b0;
        data_d  = '0;
        state_d = ST_RESP;
        case (op_q)
          OP_PUSH_BACK: begin
            if (count_q != CNT_W'(DEPTH)) begin
              ram_we    = 1'b1;
              ram_waddr = slot_of(front_q, count_q);
              count_d   = count_q + 1'b1;
              ok_d      = 1'b1;
            end
          end
          OP_PUSH_FRONT: begin
            if (count_q != CNT_W'(DEPTH)) begin
              ram_we    = 1'b1;
              ram_waddr = front_dec;
              front_d   = front_dec;
              count_d   = count_q + 1'b1;
              ok_d      = 1'b1;
            end
          end
          OP_POP_BACK: begin
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(front_q, count_q - 1'b1);
              count_d   = count_q - 1'b1;
              ok_d      = 1'b1;
              state_d   = ST_RDWAIT;
            end
          end
          OP_POP_FRONT: begin
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = front_q;
              front_d   = front_inc;
              count_d   = count_q - 1'b1;
              ok_d      = 1'b1;
              state_d   = ST_RDWAIT;
            end
          end
          OP_READ: begin
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = slot_of(front_q, read_pos);
              ok_d      = 1'b1;
              state_d   = ST_RDWAIT;
            end
          end
          OP_REMOVE: begin
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = front_q;
              idx_d     = '0;
              state_d   = ST_SCAN;
            end
          end
          OP_CLEAR: begin
            count_d = '0;
            front_d = '0;
            ok_d    = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_RDWAIT: begin
        data_d  = ram_rdata;
        state_d = ST_RESP;
      end
      ST_SCAN: begin
        // The read data belongs to entry idx; the next entry is fetched meanwhile,
        // which is also the first source entry if the gap has to be closed.
        ram_re    = 1'b1;
        ram_raddr = slot_of(front_q, CNT_W'(idx_p1));
        if (ram_rdata == val_q) begin
          if (idx_p1 == count_x) begin
            count_d = count_q - 1'b1;
            ok_d    = 1'b1;
            state_d = ST_RESP;
          end else begin
            state_d = ST_SHIFT;
          end
        end else if (idx_p1 == count_x) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(front_q, CNT_W'(idx_q));
        ram_wdata = ram_rdata;
        if (idx_p2 == count_x) begin
          count_d = count_q - 1'b1;
          ok_d    = 1'b1;
          state_d = ST_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = slot_of(front_q, CNT_W'(idx_p2));
          idx_d     = idx_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = data_q;
          m_ok_d    = ok_q;
          m_count_d = DqCountW'(count_q);
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      front_q   <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      front_q   <= front_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    val_q     <= val_d;
    pos_q     <= pos_d;
    idx_q     <= idx_d;
    data_q    <= data_d;
    ok_q      <= ok_d;
    m_data_q  <= m_data_d;
    m_ok_q    <= m_ok_d;
    m_count_q <= m_count_d;
  end

endmodule
